// ===== rtl/core/traffic_light_sequencer_core_defines.svh =====
// Assertion macros used by the traffic light sequencer core RTL.
`ifndef TRAFFIC_LIGHT_SEQUENCER_CORE_DEFINES_SVH
`define TRAFFIC_LIGHT_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define TLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TLS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/tls_pkg.sv =====
`default_nettype none
package tls_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_EMERGENCY = 2'd1,
        MODE_CAUTION   = 2'd2,
        MODE_BLINK     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_RED     = 3'd0,
        PH_YELLOW  = 3'd1,
        PH_GREEN   = 3'd2,
        PH_FLASH   = 3'd3,
        PH_HOLD    = 3'd4,
        PH_YELLOW2 = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        CFG_RED_TICKS    = 3'd0,
        CFG_YELLOW_TICKS = 3'd1,
        CFG_GREEN_TICKS  = 3'd2,
        CFG_FLASH_HALF   = 3'd3,
        CFG_FLASH_COUNT  = 3'd4,
        CFG_HOLD_TICKS   = 3'd5,
        CFG_BLINK_TICKS  = 3'd6
    } t_cfg_addr;

    localparam logic [15:0] RST_RED_TICKS    = 16'd2000;
    localparam logic [15:0] RST_YELLOW_TICKS = 16'd500;
    localparam logic [15:0] RST_GREEN_TICKS  = 16'd2000;
    localparam logic [15:0] RST_FLASH_HALF   = 16'd250;
    localparam logic [3:0]  RST_FLASH_COUNT  = 4'd3;
    localparam logic [15:0] RST_HOLD_TICKS   = 16'd1000;
    localparam logic [15:0] RST_BLINK_TICKS  = 16'd300;

    typedef struct packed {
        logic [15:0] red_ticks;
        logic [15:0] yellow_ticks;
        logic [15:0] green_ticks;
        logic [15:0] flash_half_ticks;
        logic [3:0]  flash_count;
        logic [15:0] green_hold_ticks;
        logic [15:0] blink_ticks;
    } t_cfg;

    typedef struct packed {
        logic       emergency_switch;
        logic       caution_switch;
        logic       blink_switch;
        logic [9:0] pot_sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] yellow_level;
        logic [7:0] green_level;
        t_mode      active_mode;
        t_phase     cycle_phase;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/tls_ifs.sv =====
`default_nettype none
interface tls_in_if;
    logic       valid;
    logic       ready;
    logic       emergency_switch;
    logic       caution_switch;
    logic       blink_switch;
    logic [9:0] pot_sample;

    modport source (
        output valid, emergency_switch, caution_switch, blink_switch, pot_sample,
        input  ready
    );
    modport sink (
        input  valid, emergency_switch, caution_switch, blink_switch, pot_sample,
        output ready
    );
endinterface

interface tls_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] yellow_level;
    logic [7:0] green_level;
    logic [1:0] active_mode;
    logic [2:0] cycle_phase;

    modport source (
        output valid, red_level, yellow_level, green_level, active_mode, cycle_phase,
        input  ready
    );
    modport sink (
        input  valid, red_level, yellow_level, green_level, active_mode, cycle_phase,
        output ready
    );
endinterface

interface tls_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [15:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/traffic_light_sequencer_core.sv =====
// Channel   Direction  Word
// i_in      in         emergency_switch, caution_switch, blink_switch, pot_sample
// o_out     out        red/yellow/green_level, active_mode, cycle_phase
// i_cfg     in         addr (register index), data
//
// Each word is registered on input and evaluated against the sequencer state when it
// advances; the result is then captured in the output register. A new word is
// accepted every cycle while the output register drains. A stalled output holds both
// registers; with stage 1 full, i_in.ready then drops until o_out.ready returns.
// Reset clears the handshake and the sequencer state and loads the configuration defaults.
`default_nettype none
`include "traffic_light_sequencer_core_defines.svh"
module traffic_light_sequencer_core
    import tls_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tls_in_if.sink    i_in,
    tls_out_if.source o_out,
    tls_cfg_if.sink   i_cfg
);

    logic     r_s1_valid;
    t_in_item r_s1_item;
    logic     r_out_valid;
    t_result  r_out;
    logic     s1_adv;
    t_cfg     cfg;
    t_result  seq_result;

    tls_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tls_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (s1_adv),
        .i_item   (r_s1_item),
        .o_result (seq_result)
    );

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item.emergency_switch <= i_in.emergency_switch;
            r_s1_item.caution_switch   <= i_in.caution_switch;
            r_s1_item.blink_switch     <= i_in.blink_switch;
            r_s1_item.pot_sample       <= i_in.pot_sample;
        end
        if (s1_adv) begin
            r_out <= seq_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.red_level    = r_out.red_level;
    assign o_out.yellow_level = r_out.yellow_level;
    assign o_out.green_level  = r_out.green_level;
    assign o_out.active_mode  = r_out.active_mode;
    assign o_out.cycle_phase  = r_out.cycle_phase;

    `TLS_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, s1_adv, r_out_valid)
    `TLS_ASSERT_IMP(a_phase_only_normal, i_clk, i_rst_n, o_out.valid && (o_out.active_mode != MODE_NORMAL), o_out.cycle_phase == PH_RED)
    `TLS_ASSERT_IMP(a_caution_dark, i_clk, i_rst_n, o_out.valid && (o_out.active_mode == MODE_CAUTION), (o_out.red_level == 8'd0) && (o_out.yellow_level == 8'd0) && (o_out.green_level == 8'd0))

endmodule
`default_nettype wire

// ===== rtl/core/tls_cfg_regs.sv =====
`default_nettype none
module tls_cfg_regs
    import tls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tls_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_ticks        <= RST_RED_TICKS;
            r_cfg.yellow_ticks     <= RST_YELLOW_TICKS;
            r_cfg.green_ticks      <= RST_GREEN_TICKS;
            r_cfg.flash_half_ticks <= RST_FLASH_HALF;
            r_cfg.flash_count      <= RST_FLASH_COUNT;
            r_cfg.green_hold_ticks <= RST_HOLD_TICKS;
            r_cfg.blink_ticks      <= RST_BLINK_TICKS;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_addr'(i_cfg.addr))
                CFG_RED_TICKS:    r_cfg.red_ticks        <= i_cfg.data;
                CFG_YELLOW_TICKS: r_cfg.yellow_ticks     <= i_cfg.data;
                CFG_GREEN_TICKS:  r_cfg.green_ticks      <= i_cfg.data;
                CFG_FLASH_HALF:   r_cfg.flash_half_ticks <= i_cfg.data;
                CFG_FLASH_COUNT:  r_cfg.flash_count      <= i_cfg.data[3:0];
                CFG_HOLD_TICKS:   r_cfg.green_hold_ticks <= i_cfg.data;
                CFG_BLINK_TICKS:  r_cfg.blink_ticks      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tls_seq.sv =====
`default_nettype none
module tls_seq
    import tls_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output t_result       o_result
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [4:0]  r_flash_cnt, n_flash_cnt;
    logic [15:0] r_blink_elapsed, n_blink_elapsed;
    logic        r_blink_level, n_blink_level;

    logic [7:0]  q0;
    logic [9:0]  lhs;
    logic [9:0]  rhs;
    logic [7:0]  bright;
    logic [15:0] elapsed_inc;
    logic        toggle;
    t_mode       mode;
    logic [15:0] len;
    logic [16:0] timer_inc;
    logic        phase_done;
    logic [4:0]  flash_inc;
    logic [3:0]  pairs;
    logic [4:0]  flash_limit;
    logic [7:0]  lvl_r, lvl_y, lvl_g;
    t_phase      shown;

    // Level is sample*255/1023: sample/4, less one when 255*(sample mod 4) < 3*(sample/4).
    assign q0     = i_item.pot_sample[9:2];
    assign lhs    = {i_item.pot_sample[1:0], 8'd0} - {8'd0, i_item.pot_sample[1:0]};
    assign rhs    = {2'd0, q0} + {1'b0, q0, 1'b0};
    assign bright = q0 - {7'd0, (lhs < rhs)};

    assign elapsed_inc = (r_blink_elapsed != 16'hFFFF) ? r_blink_elapsed + 16'd1
                                                      : r_blink_elapsed;
    assign toggle      = (elapsed_inc >= i_cfg.blink_ticks);

    always_comb begin
        priority if (i_item.emergency_switch) begin
            mode = MODE_EMERGENCY;
        end else if (i_item.caution_switch) begin
            mode = MODE_CAUTION;
        end else if (i_item.blink_switch) begin
            mode = MODE_BLINK;
        end else begin
            mode = MODE_NORMAL;
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_YELLOW, PH_YELLOW2: len = i_cfg.yellow_ticks;
            PH_GREEN:              len = i_cfg.green_ticks;
            PH_FLASH:              len = i_cfg.flash_half_ticks;
            PH_HOLD:               len = i_cfg.green_hold_ticks;
            default:               len = i_cfg.red_ticks;
        endcase
    end

    assign timer_inc   = {1'b0, r_timer} + 17'd1;
    assign phase_done  = !(timer_inc < {1'b0, len});
    assign flash_inc   = r_flash_cnt + 5'd1;
    assign pairs       = (i_cfg.flash_count == 4'd0) ? 4'd1 : i_cfg.flash_count;
    assign flash_limit = {pairs, 1'b0};

    always_comb begin
        n_phase         = r_phase;
        n_timer         = r_timer;
        n_flash_cnt     = r_flash_cnt;
        n_blink_elapsed = elapsed_inc;
        n_blink_level   = r_blink_level;
        lvl_r           = 8'd0;
        lvl_y           = 8'd0;
        lvl_g           = 8'd0;
        shown           = PH_RED;

        unique case (mode)
            MODE_EMERGENCY: lvl_r = bright;
            MODE_CAUTION: begin
            end
            MODE_BLINK: begin
                if (toggle) begin
                    n_blink_level   = !r_blink_level;
                    n_blink_elapsed = 16'd0;
                end
                lvl_r = {8{n_blink_level}};
                lvl_y = {8{n_blink_level}};
                lvl_g = {8{n_blink_level}};
            end
            default: begin
            end
        endcase

        if (mode != MODE_NORMAL) begin
            n_phase     = PH_RED;
            n_timer     = 16'd0;
            n_flash_cnt = 5'd0;
        end else begin
            unique case (r_phase)
                PH_YELLOW, PH_YELLOW2: begin
                    shown = r_phase;
                    lvl_y = bright;
                end
                PH_GREEN, PH_HOLD: begin
                    shown = r_phase;
                    lvl_g = bright;
                end
                PH_FLASH: begin
                    shown = r_phase;
                    lvl_g = r_flash_cnt[0] ? bright : 8'd0;
                end
                default: lvl_r = bright;
            endcase

            if (!phase_done) begin
                n_timer = timer_inc[15:0];
            end else begin
                n_timer = 16'd0;
                unique case (r_phase)
                    PH_FLASH: begin
                        if (flash_inc >= flash_limit) begin
                            n_flash_cnt = 5'd0;
                            n_phase     = PH_HOLD;
                        end else begin
                            n_flash_cnt = flash_inc;
                        end
                    end
                    PH_YELLOW: begin
                        n_phase     = PH_GREEN;
                        n_flash_cnt = 5'd0;
                    end
                    PH_GREEN: begin
                        n_phase     = PH_FLASH;
                        n_flash_cnt = 5'd0;
                    end
                    PH_HOLD: begin
                        n_phase     = PH_YELLOW2;
                        n_flash_cnt = 5'd0;
                    end
                    PH_YELLOW2: n_phase = PH_RED;
                    default:    n_phase = PH_YELLOW;
                endcase
            end
        end
    end

    assign o_result.red_level    = lvl_r;
    assign o_result.yellow_level = lvl_y;
    assign o_result.green_level  = lvl_g;
    assign o_result.active_mode  = mode;
    assign o_result.cycle_phase  = shown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_RED;
            r_timer         <= 16'd0;
            r_flash_cnt     <= 5'd0;
            r_blink_elapsed <= 16'd0;
            r_blink_level   <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_timer         <= n_timer;
            r_flash_cnt     <= n_flash_cnt;
            r_blink_elapsed <= n_blink_elapsed;
            r_blink_level   <= n_blink_level;
        end
    end

endmodule
`default_nettype wire
